### rtl/modbus_distance_frame_receiver_macros.svh
// Assertion macros shared by the checker of the distance frame receiver.
`ifndef MODBUS_DISTANCE_FRAME_RECEIVER_MACROS_SVH
`define MODBUS_DISTANCE_FRAME_RECEIVER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MDFR_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another on the next edge.
`define MDFR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/mdfr_pkg.sv
// Package with the frame position type, constants and CRC step of the receiver.
`default_nettype none

package mdfr_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  BYTE_COUNT = 8'h02;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE = 2'd1;

	// Position of the next expected byte within the frame.
	typedef enum logic [2:0] {
		POS_HUNT    = 3'd0,
		POS_FUNC    = 3'd1,
		POS_COUNT   = 3'd2,
		POS_DIST_HI = 3'd3,
		POS_DIST_LO = 3'd4,
		POS_CRC_LO  = 3'd5,
		POS_CRC_HI  = 3'd6
	} pos_t;

	// One byte of CRC-16/MODBUS, least significant bit first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

### rtl/modbus_distance_frame_receiver.sv
// Top level of the distance frame receiver: header hunt, field capture and CRC check.
// A transferred byte is held in the input register and processed from there; the
// result of the seventh frame byte is loaded into the result register at that point.
// Throughput: one byte per cycle, limited only by a result still waiting on out_stall.
// Reset: arst_n clears the position to hunting, the running CRC to all ones and
// the registers to slave address 1 and function code 3.
`default_nettype none

module modbus_distance_frame_receiver
	import mdfr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Received byte channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             rx_byte,
	// Result channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [15:0]                 distance,
	output logic                        crc_valid,
	output logic [15:0]                 received_crc,
	output logic [15:0]                 computed_crc,
	// Configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]             cfg_data
);

	// Configuration registers.
	logic [7:0] slave_address_q;
	logic [7:0] function_code_q;

	// Frame state.
	pos_t        pos_q, pos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  dist_hi_q;
	logic [7:0]  dist_lo_q;
	logic [7:0]  crc_lo_q;

	// Input register: the byte that is processed in this cycle.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic        out_valid_q;
	logic [15:0] distance_q;
	logic        crc_valid_q;
	logic [15:0] received_crc_q;
	logic [15:0] computed_crc_q;

	logic        emit;
	logic        out_free;
	logic        advance;
	logic [15:0] crc_base;
	logic [15:0] crc_fed;
	logic [15:0] rx_crc;

	// Configuration writes are always taken; the user must make them only while the block is idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'h01;
			function_code_q <= 8'h03;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SLAVE_ADDRESS) begin
				slave_address_q <= cfg_data;
			end else if (cfg_index == REG_FUNCTION_CODE) begin
				function_code_q <= cfg_data;
			end
		end
	end

	// The byte in the input register produces a result only at the last frame
	// position. Such a byte waits while the result register still holds an
	// untaken result; every other byte goes through at once.
	assign emit     = (pos_q == POS_CRC_HI);
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && emit && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Next position. Any unused position code behaves as hunting. A mismatch at
	// the function code or the byte count returns to hunting without checking
	// the same byte again as a slave address.
	always_comb begin
		pos_d = pos_q;
		unique case (pos_q)
			POS_FUNC: begin
				pos_d = (byte_s1 == function_code_q) ? POS_COUNT : POS_HUNT;
			end
			POS_COUNT: begin
				pos_d = (byte_s1 == BYTE_COUNT) ? POS_DIST_HI : POS_HUNT;
			end
			POS_DIST_HI: pos_d = POS_DIST_LO;
			POS_DIST_LO: pos_d = POS_CRC_LO;
			POS_CRC_LO:  pos_d = POS_CRC_HI;
			POS_CRC_HI:  pos_d = POS_HUNT;
			default: begin
				pos_d = (byte_s1 == slave_address_q) ? POS_FUNC : POS_HUNT;
			end
		endcase
	end

	// Running CRC. The first byte of a frame always starts from the initial
	// value; the CRC bytes themselves are not folded in.
	assign crc_base = (pos_q == POS_FUNC || pos_q == POS_COUNT || pos_q == POS_DIST_HI ||
		pos_q == POS_DIST_LO) ? crc_q : CRC_INIT;
	assign crc_fed  = crc_feed(crc_base, byte_s1);
	assign rx_crc   = {byte_s1, crc_lo_q};

	always_comb begin
		crc_d = crc_q;
		unique case (pos_q)
			POS_FUNC: begin
				crc_d = (byte_s1 == function_code_q) ? crc_fed : CRC_INIT;
			end
			POS_COUNT: begin
				crc_d = (byte_s1 == BYTE_COUNT) ? crc_fed : CRC_INIT;
			end
			POS_DIST_HI: crc_d = crc_fed;
			POS_DIST_LO: crc_d = crc_fed;
			POS_CRC_LO:  crc_d = crc_q;
			POS_CRC_HI:  crc_d = CRC_INIT;
			default: begin
				crc_d = (byte_s1 == slave_address_q) ? crc_fed : CRC_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			crc_q <= CRC_INIT;
		end else if (advance) begin
			pos_q <= pos_d;
			crc_q <= crc_d;
		end
	end

	// Captured frame fields; each is written before it is ever read.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (pos_q == POS_DIST_HI) begin
				dist_hi_q <= byte_s1;
			end
			if (pos_q == POS_DIST_LO) begin
				dist_lo_q <= byte_s1;
			end
			if (pos_q == POS_CRC_LO) begin
				crc_lo_q <= byte_s1;
			end
		end
	end

	// Result register. A new result may be loaded in the same cycle as the
	// previous one leaves in a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			distance_q     <= {dist_hi_q, dist_lo_q};
			crc_valid_q    <= (rx_crc == crc_q);
			received_crc_q <= rx_crc;
			computed_crc_q <= crc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign distance     = distance_q;
	assign crc_valid    = crc_valid_q;
	assign received_crc = received_crc_q;
	assign computed_crc = computed_crc_q;

endmodule

`default_nettype wire

### rtl/mdfr_checker.sv
// Port checker of the distance frame receiver and its binding to the top level.
`default_nettype none

`include "modbus_distance_frame_receiver_macros.svh"

module mdfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] distance,
	input wire logic        crc_valid,
	input wire logic [15:0] received_crc,
	input wire logic [15:0] computed_crc
);

	logic        crc_match;
	logic [48:0] result_w;

	assign crc_match = (received_crc == computed_crc);
	assign result_w  = {distance, crc_valid, received_crc, computed_crc};

	// The flag must agree with the two CRCs it is derived from.
	`MDFR_ASSERT(a_crc_flag, !out_valid || (crc_valid == crc_match), "crc_valid disagrees")

	// Input back-pressure arises only from a result that is waiting.
	`MDFR_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "stall with no result")

	`MDFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result withdrawn")

	`MDFR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_w), "result changed")

endmodule

bind modbus_distance_frame_receiver mdfr_checker u_mdfr_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the distance frame receiver: directed table, then random frames.
`timescale 1ns / 1ps

module tb_top;
	import mdfr_pkg::*;

	// Register indexes beyond the two real registers; writes to them must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	// CRC-16/MODBUS parameters, kept here so the prediction owes nothing to the design.
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
	localparam logic [7:0]  COUNT_BYTE    = 8'h02;

	localparam int NUM_PHASES        = 6;
	localparam int PHASE_FRAME_BYTES = 240;
	localparam int LONG_HOLD_CYCLES  = 300;
	// A byte is processed from the input register, and that processing is also what loads
	// any result, so this settle wait is ample for the block to come to rest.
	localparam int SETTLE_CYCLES     = 4;
	localparam int END_WAIT_CYCLES   = 5000;
	localparam int NUM_DIRECTED      = 22;

	// One frame result as the block should present it.
	typedef struct packed {
		logic [15:0] dist_word;
		logic        crc_ok;
		logic [15:0] rx_crc;
		logic [15:0] calc_crc;
	} frame_result_t;

	// One row of the directed table. Where typed is set, the distance and the received
	// CRC of the result caused by this byte are given here rather than by the predictor.
	typedef struct packed {
		logic [7:0]  b;
		logic        typed;
		logic [15:0] dist_word;
		logic [15:0] rx_crc;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             rx_byte;
	logic                   out_valid;
	logic                   out_stall;
	logic [15:0]            distance;
	logic                   crc_valid;
	logic [15:0]            received_crc;
	logic [15:0]            computed_crc;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	// Predictor state: the frame position, the running CRC and the captured fields,
	// together with its own copy of the two header registers.
	pos_t        frame_pos;
	logic [15:0] crc_acc;
	logic [7:0]  dist_msb;
	logic [7:0]  dist_lsb;
	logic [7:0]  crc_lsb;
	logic [7:0]  cfg_addr;
	logic [7:0]  cfg_func;

	// Results predicted but not yet seen on the output channel, oldest first.
	frame_result_t pending_results[$];
	stim_row_t     directed_rows[NUM_DIRECTED];

	int mismatches    = 0;
	int phase_bytes   = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	bit idle_on       = 1'b1;

	modbus_distance_frame_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.crc_valid    (crc_valid),
		.received_crc (received_crc),
		.computed_crc (computed_crc),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns period: two nanoseconds low, two high.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Backstop: a correct run needs well under a tenth of this.
	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Serial form of the reflected CRC: each data bit, least significant first, is
	// folded into the feedback as the register shifts right.
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ d[i]) begin
				r = {1'b0, r[15:1]} ^ CRC_POLY_REFL;
			end else begin
				r = {1'b0, r[15:1]};
			end
		end
		return r;
	endfunction

	function void hunt_again();
		frame_pos = POS_HUNT;
		crc_acc   = CRC_SEED;
	endfunction

	// Advance the predictor by one accepted byte; the seventh frame byte queues a result.
	function void predict_byte(input logic [7:0] b);
		frame_result_t r;
		case (frame_pos)
			POS_FUNC: begin
				// A wrong function code drops back to hunting; the byte itself is not
				// reconsidered as the start of a new frame.
				if (b != cfg_func) begin
					hunt_again();
				end else begin
					crc_acc   = crc16_step(crc_acc, b);
					frame_pos = POS_COUNT;
				end
			end
			POS_COUNT: begin
				if (b != COUNT_BYTE) begin
					hunt_again();
				end else begin
					crc_acc   = crc16_step(crc_acc, b);
					frame_pos = POS_DIST_HI;
				end
			end
			POS_DIST_HI: begin
				dist_msb  = b;
				crc_acc   = crc16_step(crc_acc, b);
				frame_pos = POS_DIST_LO;
			end
			POS_DIST_LO: begin
				dist_lsb  = b;
				crc_acc   = crc16_step(crc_acc, b);
				frame_pos = POS_CRC_LO;
			end
			POS_CRC_LO: begin
				crc_lsb   = b;
				frame_pos = POS_CRC_HI;
			end
			POS_CRC_HI: begin
				// A CRC error still yields a result, only with the valid flag clear.
				r.dist_word = {dist_msb, dist_lsb};
				r.rx_crc    = {b, crc_lsb};
				r.calc_crc  = crc_acc;
				r.crc_ok    = (r.rx_crc == crc_acc);
				pending_results.push_back(r);
				hunt_again();
			end
			default: begin
				// Hunting, and the unused position value, which behaves the same way.
				if (b != cfg_addr) begin
					hunt_again();
				end else begin
					crc_acc   = crc16_step(CRC_SEED, b);
					frame_pos = POS_FUNC;
				end
			end
		endcase
	endfunction

	// Offer one byte, possibly after an idle burst, and hold it until its transfer.
	// Called at a falling edge and returns at the falling edge after the transfer,
	// having made no assignment there, so the next byte may follow at once.
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		predict_byte(b);
		@(negedge clk);
	endtask

	// Register write over the configuration channel; only made while the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SLAVE_ADDRESS) begin
			cfg_addr = v;
		end else if (idx == REG_FUNCTION_CODE) begin
			cfg_func = v;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering bytes and wait until every predicted result has been seen, then let
	// the block settle, since a trailing byte may cause no result at all.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One random sequence under the current header registers: mostly whole frames with
	// random content, some with a damaged CRC, some with a broken header, and some noise.
	task automatic send_frame();
		int unsigned pick;
		int          n;
		logic [7:0]  fb[7];
		logic [15:0] c;
		pick  = $urandom_range(0, 99);
		fb[0] = cfg_addr;
		fb[1] = cfg_func;
		fb[2] = COUNT_BYTE;
		case ($urandom_range(0, 9))
			0:       {fb[3], fb[4]} = 16'h0000;
			1:       {fb[3], fb[4]} = 16'hFFFF;
			default: {fb[3], fb[4]} = 16'($urandom);
		endcase
		c = CRC_SEED;
		for (int i = 0; i < 5; i++) begin
			c = crc16_step(c, fb[i]);
		end
		if (pick >= 55 && pick < 75) begin
			if ($urandom_range(0, 1) == 1) begin
				c = c ^ (16'h0001 << $urandom_range(0, 15));
			end else begin
				c = 16'($urandom);
			end
		end
		fb[5] = c[7:0];
		fb[6] = c[15:8];
		n     = 7;
		if (pick >= 75 && pick < 88) begin
			// Wrong function code or wrong byte count: a non-zero mask forces the mismatch.
			n         = $urandom_range(2, 3);
			fb[n - 1] = fb[n - 1] ^ 8'($urandom_range(1, 255));
		end else if (pick >= 88) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				fb[i] = 8'($urandom);
			end
		end
		for (int i = 0; i < n; i++) begin
			send_byte(fb[i]);
		end
		phase_bytes = phase_bytes + n;
	endtask

	// Receiver side: random stall bursts while idling is allowed, and, on request from the
	// stimulus, one long hold-off so that the block fills up and has to stall its input.
	// Each pass makes one assignment at a falling edge.
	initial begin : result_stall
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = holds_served + 1;
				out_stall   <= 1'b1;
				hold         = LONG_HOLD_CYCLES;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				hold       = $urandom_range(1, 9);
			end else begin
				out_stall <= 1'b0;
				hold       = 1;
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	// Every result transfer is compared field by field with the oldest prediction.
	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, distance %h received_crc %h", $time,
					distance, received_crc);
				mismatches = mismatches + 1;
			end else begin
				want = pending_results.pop_front();
				if (distance !== want.dist_word) begin
					$display("%0t: distance expected %h actual %h", $time, want.dist_word,
						distance);
					mismatches = mismatches + 1;
				end
				if (crc_valid !== want.crc_ok) begin
					$display("%0t: crc_valid expected %b actual %b", $time, want.crc_ok,
						crc_valid);
					mismatches = mismatches + 1;
				end
				if (received_crc !== want.rx_crc) begin
					$display("%0t: received_crc expected %h actual %h", $time, want.rx_crc,
						received_crc);
					mismatches = mismatches + 1;
				end
				if (computed_crc !== want.calc_crc) begin
					$display("%0t: computed_crc expected %h actual %h", $time, want.calc_crc,
						computed_crc);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	initial begin : stimulus
		logic [7:0]    addr_set[NUM_PHASES];
		logic [7:0]    func_set[NUM_PHASES];
		frame_result_t typed_result;
		bit            paused;
		int            waited;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_SLAVE_ADDRESS;
		cfg_data  = 8'h00;
		cfg_addr  = 8'h01;
		cfg_func  = 8'h03;
		dist_msb  = 8'h00;
		dist_lsb  = 8'h00;
		crc_lsb   = 8'h00;
		paused    = 1'b0;
		hunt_again();

		// Header settings per phase: all zeros, all ones, mixed extremes, both equal to
		// the byte count, a random pair, and the reset values for the quiet final phase.
		addr_set = '{8'h00, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h01};
		func_set = '{8'h00, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h03};
		addr_set[4] = 8'($urandom);
		func_set[4] = 8'($urandom);

		// Directed table under the reset header (address 1, function 3): frames with the
		// extreme distance and CRC values, a stray byte while hunting, a wrong function
		// code whose byte must not restart the hunt, and a wrong byte count.
		directed_rows = '{
			'{8'h01, 1'b0, 16'h0000, 16'h0000},
			'{8'h03, 1'b0, 16'h0000, 16'h0000},
			'{8'h02, 1'b0, 16'h0000, 16'h0000},
			'{8'h00, 1'b0, 16'h0000, 16'h0000},
			'{8'h00, 1'b0, 16'h0000, 16'h0000},
			'{8'h00, 1'b0, 16'h0000, 16'h0000},
			'{8'h00, 1'b1, 16'h0000, 16'h0000},
			'{8'h01, 1'b0, 16'h0000, 16'h0000},
			'{8'h03, 1'b0, 16'h0000, 16'h0000},
			'{8'h02, 1'b0, 16'h0000, 16'h0000},
			'{8'hFF, 1'b0, 16'h0000, 16'h0000},
			'{8'hFF, 1'b0, 16'h0000, 16'h0000},
			'{8'hFF, 1'b0, 16'h0000, 16'h0000},
			'{8'hFF, 1'b1, 16'hFFFF, 16'hFFFF},
			'{8'h55, 1'b0, 16'h0000, 16'h0000},
			'{8'h01, 1'b0, 16'h0000, 16'h0000},
			'{8'h01, 1'b0, 16'h0000, 16'h0000},
			'{8'h03, 1'b0, 16'h0000, 16'h0000},
			'{8'h02, 1'b0, 16'h0000, 16'h0000},
			'{8'h01, 1'b0, 16'h0000, 16'h0000},
			'{8'h03, 1'b0, 16'h0000, 16'h0000},
			'{8'h01, 1'b0, 16'h0000, 16'h0000}
		};

		// Reset is asserted from the start and released at a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Writes to the spare indexes must leave the reset header in place.
		write_reg(REG_SPARE_2, 8'h55);
		write_reg(REG_SPARE_3, 8'hAA);

		foreach (directed_rows[k]) begin
			send_byte(directed_rows[k].b);
			// The transfer has just been predicted and its result can come only at a later edge,
			// so the newest prediction can still be overridden by the table.
			if (directed_rows[k].typed && pending_results.size() != 0) begin
				typed_result           = pending_results.pop_back();
				typed_result.dist_word = directed_rows[k].dist_word;
				typed_result.rx_crc    = directed_rows[k].rx_crc;
				pending_results.push_back(typed_result);
			end
		end
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_SLAVE_ADDRESS, addr_set[p]);
			write_reg(REG_FUNCTION_CODE, func_set[p]);
			if (p == 3) begin
				write_reg(REG_SPARE_2, 8'($urandom));
				write_reg(REG_SPARE_3, 8'($urandom));
			end
			// The last phase runs at full rate on both sides.
			idle_on = (p != NUM_PHASES - 1);
			// A long receiver hold-off while bytes keep coming fills the block up.
			if (p == 1) begin
				hold_requests = hold_requests + 1;
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_FRAME_BYTES) begin
				send_frame();
				// Once, the sender waits mid-phase for every outstanding result.
				if (p == 2 && !paused && phase_bytes >= PHASE_FRAME_BYTES / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
			if (p != NUM_PHASES - 1) begin
				drain_results();
			end
		end

		// End of stimulus: wait, within a bound, for the last results, then a little more
		// so that any surplus result would still be caught by the checker.
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < END_WAIT_CYCLES) begin
			@(negedge clk);
			waited = waited + 1;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time,
				pending_results.size());
		end
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

### modbus_distance_frame_receiver.f
+incdir+rtl
rtl/mdfr_pkg.sv
rtl/modbus_distance_frame_receiver.sv
rtl/mdfr_checker.sv
tb/tb_top.sv
